FILE: rtl/core/lznt1_pkg.sv
package lznt1_pkg;

    localparam int BLOCK_SIZE_DEF = 4096;
    localparam int WIN_AW = $clog2(BLOCK_SIZE_DEF);

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_HDR_LO = 4'd1,
        PH_HDR_HI = 4'd2,
        PH_STORED = 4'd3,
        PH_TAG    = 4'd4,
        PH_TOKEN  = 4'd5,
        PH_REF_HI = 4'd6,
        PH_COPY   = 4'd7,
        PH_PAD    = 4'd8,
        PH_DONE   = 4'd9,
        PH_ERROR  = 4'd10
    } phase_t;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_OUT_SHORT = 3'd1;
    localparam logic [2:0] ERR_DATA_SHORT = 3'd2;
    localparam logic [2:0] ERR_PAST_DATA = 3'd3;
    localparam logic [2:0] ERR_RAW_FULL = 3'd4;
    localparam logic [2:0] ERR_REF_FIRST = 3'd5;
    localparam logic [2:0] ERR_REF_FAR  = 3'd6;
    localparam logic [2:0] ERR_OVERFLOW = 3'd7;

    typedef struct packed {
        logic              we;
        logic [WIN_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [WIN_AW-1:0] raddr;
    } win_req_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       accepted;
        logic       block_last;
        logic       done_res;
        logic [2:0] error;
    } res_t;

endpackage

FILE: rtl/core/lznt1_window.sv
module lznt1_window
    import lznt1_pkg::*;
(
    input  logic       aclk,
    input  win_req_t   req,
    output logic [7:0] rdata
);

    logic [7:0] mem [0:BLOCK_SIZE_DEF-1];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/lznt1_decompressor.sv
// LZNT1 decompressor. Each request carries a command (start, compressed byte, tick) and
// a byte, and produces exactly one registered result the next cycle; a request is taken
// every cycle while the result register is free or being drained. Copy bytes come from
// a 4096-byte window with a registered read port, the last written byte forwarded so
// that overlapping copies run at one byte per tick. The window needs no clearing pass.
module lznt1_decompressor
    import lznt1_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // command[1:0], data[9:2], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // out_valid, out_byte[8:1], accepted, block_last,
                                    // done_res, error[14:12], zero fill
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int BLOCK_SIZE = BLOCK_SIZE_DEF;
    localparam int PW = $clog2(BLOCK_SIZE) + 1;
    localparam int AW = PW - 1;

    phase_t      phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next, left_reg, left_next, cleft_reg, cleft_next;
    logic [7:0]  hlo_reg, hlo_next, tag_reg, tag_next, tlo_reg, tlo_next;
    logic [3:0]  tidx_reg, tidx_next;
    logic [AW-1:0] dist_reg, dist_next;
    logic [31:0] cons_reg, cons_next, prod_reg, prod_next, srcl_reg, outl_reg;
    logic [2:0]  err_reg, err_next;
    logic        mv_reg;
    res_t        res_reg, res_next;
    logic [7:0]  lastw_reg;
    logic        fwd_reg, fwd_next;
    win_req_t    wreq;
    logic [7:0]  rdata;

    cmd_t        cmd;
    logic [7:0]  din;
    logic        take;
    logic        emit;
    logic [7:0]  ebyte;
    logic [15:0] hdr, tok;
    logic [3:0]  msh;
    logic [PW-1:0] pm1;
    logic [PW:0] back_dist, len;
    logic [32:0] prod_blk;
    logic [AW-1:0] src;

    assign s_tready = !mv_reg || m_tready;
    assign take = s_tvalid && s_tready;
    assign cmd = cmd_t'(s_tdata[1:0]);
    assign din = s_tdata[9:2];
    assign prod_blk = {1'b0, prod_reg} + 33'(BLOCK_SIZE);
    assign pm1 = pos_reg - PW'(1);

    always_comb begin
        msh = '0;
        for (int k = 4; k < PW - 1; k++) begin
            if (pm1 >= PW'(1 << k)) msh = 4'(k - 3);
        end
    end

    assign tok  = {din, tlo_reg};
    assign back_dist = (PW+1)'(tok >> (4'd12 - msh)) + (PW+1)'(1);
    assign len  = (PW+1)'(tok & (16'h0fff >> msh)) + (PW+1)'(3);
    assign hdr  = {din, hlo_reg};
    assign src  = AW'(pos_reg - PW'(1) - PW'(dist_reg));

    logic [7:0] copy_byte;
    assign copy_byte = fwd_reg ? lastw_reg : rdata;

    always_comb begin
        phase_next = phase_reg; pos_next = pos_reg; left_next = left_reg;
        cleft_next = cleft_reg; hlo_next = hlo_reg; tag_next = tag_reg;
        tlo_next = tlo_reg; tidx_next = tidx_reg; dist_next = dist_reg;
        cons_next = cons_reg; prod_next = prod_reg; err_next = err_reg;
        emit = 1'b0; ebyte = '0;
        res_next = res_reg;
        fwd_next = fwd_reg;
        if (take) begin
            res_next = '0;
            case (cmd)
                CMD_START: begin
                    cons_next = '0; prod_next = '0; err_next = ERR_NONE; left_next = '0;
                    hlo_next = '0; tag_next = '0; tidx_next = '0; tlo_next = '0;
                    dist_next = '0; cleft_next = '0; pos_next = '0;
                    phase_next = (srcl_reg == 0 || outl_reg == 0) ? PH_DONE : PH_HDR_LO;
                end
                CMD_BYTE: begin
                    if (phase_reg inside {[PH_HDR_LO:PH_REF_HI]}) begin
                        res_next.accepted = 1'b1;
                        cons_next = cons_reg + 32'd1;
                        case (phase_reg)
                            PH_HDR_LO: begin
                                hlo_next = din;
                                if (cons_next >= srcl_reg) begin
                                    if (din == 0) phase_next = PH_DONE;
                                    else if (prod_blk > {1'b0, outl_reg}) err_next = ERR_OUT_SHORT;
                                    else err_next = ERR_DATA_SHORT;
                                end else phase_next = PH_HDR_HI;
                            end
                            PH_HDR_HI: begin
                                pos_next = '0;
                                if (hdr == 0) phase_next = PH_DONE;
                                else if (prod_blk > {1'b0, outl_reg}) err_next = ERR_OUT_SHORT;
                                else if ({1'b0, cons_next} + 33'd4 > {1'b0, srcl_reg})
                                    err_next = ERR_DATA_SHORT;
                                else if ({1'b0, cons_next} + 33'(hdr[11:0]) + 33'd1
                                         > {1'b0, srcl_reg})
                                    err_next = ERR_PAST_DATA;
                                else if (!hdr[15]) begin
                                    if (32'(hdr[11:0]) + 32'd1 != 32'(BLOCK_SIZE))
                                        err_next = ERR_RAW_FULL;
                                    else begin
                                        left_next = PW'(BLOCK_SIZE); phase_next = PH_STORED;
                                    end
                                end else begin
                                    left_next = PW'(hdr[11:0]) + PW'(1); phase_next = PH_TAG;
                                end
                            end
                            PH_STORED: begin
                                emit = 1'b1; ebyte = din;
                                left_next = left_reg - PW'(1);
                            end
                            PH_TAG: begin
                                tag_next = din; tidx_next = '0;
                                left_next = left_reg - PW'(1);
                            end
                            PH_TOKEN: begin
                                left_next = left_reg - PW'(1);
                                tidx_next = tidx_reg + 4'd1;
                                if (!tag_reg[tidx_reg[2:0]]) begin
                                    if (pos_reg >= PW'(BLOCK_SIZE)) err_next = ERR_OVERFLOW;
                                    else begin emit = 1'b1; ebyte = din; end
                                end else if (pos_reg == 0) err_next = ERR_REF_FIRST;
                                else if (left_next == 0) err_next = ERR_DATA_SHORT;
                                else begin tlo_next = din; phase_next = PH_REF_HI; end
                            end
                            PH_REF_HI: begin
                                left_next = left_reg - PW'(1);
                                if (back_dist > (PW+1)'(pos_reg)) err_next = ERR_REF_FAR;
                                else if ((PW+1)'(pos_reg) + len > (PW+1)'(BLOCK_SIZE))
                                    err_next = ERR_OVERFLOW;
                                else begin
                                    dist_next = AW'(back_dist - (PW+1)'(1));
                                    cleft_next = PW'(len);
                                    phase_next = PH_COPY;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                CMD_TICK: begin
                    if (phase_reg == PH_COPY) begin
                        emit = 1'b1; ebyte = copy_byte;
                        cleft_next = cleft_reg - PW'(1);
                    end else if (phase_reg == PH_PAD) begin
                        emit = 1'b1; ebyte = '0;
                    end
                end
                default: ;
            endcase
            if (cmd != CMD_START && err_next != err_reg) begin
                phase_next = PH_ERROR; cleft_next = '0;
            end
            if (emit) begin
                pos_next = pos_reg + PW'(1);
                prod_next = prod_reg + 32'd1;
                res_next.out_valid = 1'b1;
                res_next.out_byte = ebyte;
                res_next.block_last = (pos_next == PW'(BLOCK_SIZE));
            end
            if (err_next == err_reg && cmd != CMD_START) begin
                if ((phase_reg == PH_STORED && left_next == 0)
                    || (phase_reg == PH_PAD && pos_next >= PW'(BLOCK_SIZE))) begin
                    pos_next = '0;
                    phase_next = (cons_next >= srcl_reg || prod_next >= outl_reg)
                                 ? PH_DONE : PH_HDR_LO;
                end else if ((phase_reg == PH_TAG)
                    || (phase_reg == PH_TOKEN && phase_next == PH_TOKEN)
                    || (phase_reg == PH_COPY && cmd == CMD_TICK && cleft_next == 0)) begin
                    if (left_next == 0) begin
                        if (pos_next < PW'(BLOCK_SIZE)) phase_next = PH_PAD;
                        else begin
                            pos_next = '0;
                            phase_next = (cons_next >= srcl_reg || prod_next >= outl_reg)
                                         ? PH_DONE : PH_HDR_LO;
                        end
                    end else if (tidx_next >= 4'd8) phase_next = PH_TAG;
                    else phase_next = PH_TOKEN;
                end
            end
            res_next.done_res = (phase_next == PH_DONE);
            res_next.error = err_next;
            // Forward when the next copy read hits the byte written this cycle.
            fwd_next = emit && (phase_next == PH_COPY) && (dist_next == '0);
        end
    end

    always_comb begin
        wreq.we = take && emit;
        wreq.waddr = AW'(pos_reg);
        wreq.wdata = ebyte;
        wreq.re = 1'b1;
        wreq.raddr = take ? AW'(pos_next - PW'(1) - PW'(dist_next)) : src;
    end

    lznt1_window u_window (
        .aclk  (aclk),
        .req   (wreq),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; pos_reg <= '0; left_reg <= '0; cleft_reg <= '0;
            hlo_reg <= '0; tag_reg <= '0; tlo_reg <= '0; tidx_reg <= '0; dist_reg <= '0;
            cons_reg <= '0; prod_reg <= '0; err_reg <= '0; mv_reg <= 1'b0;
            srcl_reg <= '0; outl_reg <= '0; fwd_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; pos_reg <= pos_next; left_reg <= left_next;
            cleft_reg <= cleft_next; hlo_reg <= hlo_next; tag_reg <= tag_next;
            tlo_reg <= tlo_next; tidx_reg <= tidx_next; dist_reg <= dist_next;
            cons_reg <= cons_next; prod_reg <= prod_next; err_reg <= err_next;
            fwd_reg <= fwd_next;
            if (take) mv_reg <= 1'b1;
            else if (m_tready) mv_reg <= 1'b0;
            if (cfg_we) begin
                if (cfg_index) outl_reg <= cfg_data;
                else srcl_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (take && emit) lastw_reg <= ebyte;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata = {1'b0, res_reg.error, res_reg.done_res, res_reg.block_last,
                      res_reg.accepted, res_reg.out_byte, res_reg.out_valid};

    assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ERR_NONE) |-> (phase_reg == PH_ERROR))
        else $error("error code without error phase");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_COPY) |-> (cleft_reg != '0))
        else $error("copy phase with nothing left");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_tready) |=> $stable(res_reg))
        else $error("held result changed");

endmodule
